// ===== hdl/swdc_pkg.sv =====
`default_nettype none
package swdc_pkg;

	// Fixed widths of the item fields
	localparam int PW        = 10;               // position / value field width
	localparam int CW        = 11;               // per-value count and distinct count width
	localparam int MOD_STEPS = 2;                // multiply steps in the value reduction
	localparam int MOD_W     = $clog2(MOD_STEPS + 1);   // steps left in the value reduction

	// Word kinds on the input channel
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;     // take the accepted word into the item registers
		logic clear_step;  // zero one count entry after reset
		logic mod_step;    // one step of the value reduction
		logic ld_out;      // aim a count-out at the load position
		logic ld_in;       // aim a count-in at the load position
		logic elem_write;  // write the loaded value into the element store
		logic seed;        // open the window on the left end of the query
		logic plan_step;   // move one window edge by one position
		logic elem_read;   // read the element at the aimed position
		logic cnt_read;    // read the count of that element's value
		logic cnt_update;  // write the count back and fix the distinct count
		logic out_load;    // load the result into the output register
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic clear_last;  // last count entry is being cleared
		logic mod_done;    // loaded value is below the value range
		logic pos_oob;     // load position beyond the array
		logic in_win;      // load position lies in the current window
		logic bad;         // query left end beyond right end
		logic empty;       // window holds nothing yet
		logic win_done;    // window matches the query range
		logic out_free;    // output register can take a result
	} sts_t;

endpackage
`default_nettype wire

// ===== hdl/swdc_ram.sv =====
`default_nettype none
module swdc_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== hdl/swdc_ctrl.sv =====
`default_nettype none
module swdc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           mode,
	output      logic           in_ready,
	output      swdc_pkg::cmd_t cmd,
	input  wire swdc_pkg::sts_t sts
);
	import swdc_pkg::*;

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_MOD    = 4'd2;
	localparam logic [3:0] ST_LD_CHK = 4'd3;
	localparam logic [3:0] ST_LD_WR  = 4'd4;
	localparam logic [3:0] ST_QCHK   = 4'd5;
	localparam logic [3:0] ST_PLAN   = 4'd6;
	localparam logic [3:0] ST_ELEM   = 4'd7;
	localparam logic [3:0] ST_CNT    = 4'd8;
	localparam logic [3:0] ST_UPD    = 4'd9;
	localparam logic [3:0] ST_DONE   = 4'd10;

	logic [3:0] state_q, state_d;
	logic       qry_q;   // current word is a query
	logic       ldin_q;  // load has passed its store write

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = (mode == MODE_LOAD) ? ST_MOD : ST_QCHK;
				end
			end
			ST_MOD: begin
				if (sts.pos_oob) begin
					state_d = ST_IDLE;
				end else if (sts.mod_done) begin
					state_d = ST_LD_CHK;
				end else begin
					cmd.mod_step = 1'b1;
				end
			end
			ST_LD_CHK: begin
				if (sts.in_win) begin
					cmd.ld_out = 1'b1;
					state_d    = ST_ELEM;
				end else begin
					state_d = ST_LD_WR;
				end
			end
			ST_LD_WR: begin
				cmd.elem_write = 1'b1;
				if (sts.in_win) begin
					cmd.ld_in = 1'b1;
					state_d   = ST_ELEM;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_QCHK: begin
				if (sts.bad) begin
					state_d = ST_DONE;
				end else if (sts.empty) begin
					cmd.seed = 1'b1;
					state_d  = ST_ELEM;
				end else begin
					state_d = ST_PLAN;
				end
			end
			ST_PLAN: begin
				if (sts.win_done) begin
					state_d = ST_DONE;
				end else begin
					cmd.plan_step = 1'b1;
					state_d       = ST_ELEM;
				end
			end
			ST_ELEM: begin
				cmd.elem_read = 1'b1;
				state_d       = ST_CNT;
			end
			ST_CNT: begin
				cmd.cnt_read = 1'b1;
				state_d      = ST_UPD;
			end
			ST_UPD: begin
				cmd.cnt_update = 1'b1;
				if (qry_q) begin
					state_d = ST_PLAN;
				end else if (ldin_q) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_LD_WR;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and job flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			qry_q   <= 1'b0;
			ldin_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) begin
				qry_q  <= (mode != MODE_LOAD);
				ldin_q <= 1'b0;
			end else if (cmd.elem_write) begin
				ldin_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/swdc_dp.sv =====
`default_nettype none
module swdc_dp #(
	parameter int ARRAY_DEPTH = 1024,
	parameter int VALUE_RANGE = 1024
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire swdc_pkg::cmd_t          cmd,
	output      swdc_pkg::sts_t          sts,
	input  wire logic [swdc_pkg::PW-1:0] position,
	input  wire logic [swdc_pkg::PW-1:0] elem_value,
	input  wire logic [swdc_pkg::PW-1:0] left_end,
	input  wire logic [swdc_pkg::PW-1:0] right_end,
	output      logic                    out_valid,
	input  wire logic                    out_ready,
	output      logic [swdc_pkg::CW-1:0] distinct_count,
	output      logic                    bad_query
);
	import swdc_pkg::*;

	localparam int          AW       = $clog2(ARRAY_DEPTH);
	localparam int          VW       = $clog2(VALUE_RANGE);
	localparam logic [31:0] LAST_POS = 32'(ARRAY_DEPTH - 1);
	localparam logic [VW-1:0] LAST_VAL = VW'(VALUE_RANGE - 1);
	localparam bit          NEED_MOD = (VALUE_RANGE < (1 << PW));
	// Reciprocal of the value range: floor(v / range) = (v * RECIP) >> RS
	localparam int          RS       = PW + VW;
	localparam longint      RECIP    = ((longint'(1) << RS) + longint'(VALUE_RANGE) - 1)
	                                   / longint'(VALUE_RANGE);
	localparam int          MW       = 2 * PW + 2;
	localparam int          SW       = 2 * PW;
	localparam logic [PW+1:0] RECIP_C = (PW + 2)'(RECIP);

	// Item registers
	logic [PW-1:0]    pos_q, val_q, lq_q, rq_q;
	logic             bad_q;
	logic [MOD_W-1:0] mcnt_q;
	logic [PW-1:0]    quo_q;

	// Window state
	logic [PW-1:0] lo_q, hi_q;
	logic          empty_q;
	logic [CW-1:0] distinct_q;

	// Step registers
	logic [PW-1:0] p_q;
	logic          dir_q;   // 1: count in, 0: count out
	logic [VW-1:0] v_q;
	logic [VW-1:0] clr_q;

	// Output register
	logic          out_valid_q;
	logic [CW-1:0] out_cnt_q;
	logic          out_bad_q;

	// RAM ports
	logic [VW-1:0] elem_rd;
	logic [CW-1:0] cnt_rd, cnt_new;
	logic          cnt_we;

	// Query end saturation and value reduction products
	logic [PW-1:0]    lq_sat, rq_sat;
	logic [MOD_W-1:0] mod_idx;
	logic [MW-1:0]    mod_prod;
	logic [SW-1:0]    mod_sub;

	always_comb begin
		lq_sat   = (32'(left_end) > LAST_POS) ? PW'(LAST_POS) : left_end;
		rq_sat   = (32'(right_end) > LAST_POS) ? PW'(LAST_POS) : right_end;
		mod_idx  = mcnt_q - MOD_W'(1);
		mod_prod = MW'(val_q) * MW'(RECIP_C);
		mod_sub  = SW'(quo_q) * SW'(VALUE_RANGE);
	end

	// Status toward the controller
	always_comb begin
		sts.clear_last = (clr_q == LAST_VAL);
		sts.mod_done   = !NEED_MOD || (mcnt_q == '0);
		sts.pos_oob    = (32'(pos_q) > LAST_POS);
		sts.in_win     = !empty_q && (pos_q >= lo_q) && (pos_q <= hi_q);
		sts.bad        = bad_q;
		sts.empty      = empty_q;
		sts.win_done   = (lo_q == lq_q) && (hi_q == rq_q);
		sts.out_free   = !out_valid_q || out_ready;
	end

	// Item capture and value reduction: quotient first, then remainder
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pos_q  <= position;
			val_q  <= elem_value;
			lq_q   <= lq_sat;
			rq_q   <= rq_sat;
			bad_q  <= (left_end > right_end);
			mcnt_q <= MOD_W'(MOD_STEPS);
		end else if (cmd.mod_step) begin
			if (mcnt_q == MOD_W'(MOD_STEPS)) begin
				quo_q <= PW'(mod_prod >> RS);
			end else begin
				val_q <= val_q - PW'(mod_sub);
			end
			mcnt_q <= mod_idx;
		end
	end

	// Window seed at the query's left end, and moves of one position at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q    <= '0;
			hi_q    <= '0;
			empty_q <= 1'b1;
		end else if (cmd.seed) begin
			lo_q    <= lq_q;
			hi_q    <= lq_q;
			empty_q <= 1'b0;
		end else if (cmd.plan_step) begin
			if (lo_q > lq_q) begin
				lo_q <= lo_q - PW'(1);
			end else if (hi_q < rq_q) begin
				hi_q <= hi_q + PW'(1);
			end else if (lo_q < lq_q) begin
				lo_q <= lo_q + PW'(1);
			end else if (hi_q > rq_q) begin
				hi_q <= hi_q - PW'(1);
			end
		end
	end

	// Aimed position and direction of the next count step, and the value read
	always_ff @(posedge clk) begin
		if (cmd.seed) begin
			p_q   <= lq_q;
			dir_q <= 1'b1;
		end else if (cmd.ld_out) begin
			p_q   <= pos_q;
			dir_q <= 1'b0;
		end else if (cmd.ld_in) begin
			p_q   <= pos_q;
			dir_q <= 1'b1;
		end else if (cmd.plan_step) begin
			if (lo_q > lq_q) begin
				p_q   <= lo_q - PW'(1);
				dir_q <= 1'b1;
			end else if (hi_q < rq_q) begin
				p_q   <= hi_q + PW'(1);
				dir_q <= 1'b1;
			end else if (lo_q < lq_q) begin
				p_q   <= lo_q;
				dir_q <= 1'b0;
			end else begin
				p_q   <= hi_q;
				dir_q <= 1'b0;
			end
		end
		if (cmd.cnt_read) begin
			v_q <= elem_rd;
		end
	end

	// Count table write back
	always_comb begin
		cnt_new = dir_q ? (cnt_rd + CW'(1)) : (cnt_rd - CW'(1));
		cnt_we  = cmd.clear_step || (cmd.cnt_update && (dir_q || (cnt_rd != '0)));
	end

	// Clear sweep and running distinct count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			distinct_q <= '0;
		end else begin
			if (cmd.clear_step) begin
				clr_q <= clr_q + VW'(1);
			end
			if (cmd.cnt_update) begin
				if (dir_q) begin
					if (cnt_rd == '0) begin
						distinct_q <= distinct_q + CW'(1);
					end
				end else if ((cnt_rd == CW'(1)) && (distinct_q != '0)) begin
					distinct_q <= distinct_q - CW'(1);
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_cnt_q <= bad_q ? '0 : distinct_q;
			out_bad_q <= bad_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign distinct_count = out_cnt_q;
	assign bad_query      = out_bad_q;

	// Element store
	swdc_ram #(
		.WIDTH(VW),
		.DEPTH(ARRAY_DEPTH)
	) u_elem_ram (
		.clk  (clk),
		.we   (cmd.elem_write),
		.waddr(AW'(pos_q)),
		.wdata(VW'(val_q)),
		.re   (cmd.elem_read),
		.raddr(AW'(p_q)),
		.rdata(elem_rd)
	);

	// Per-value count table
	swdc_ram #(
		.WIDTH(CW),
		.DEPTH(VALUE_RANGE)
	) u_cnt_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cmd.clear_step ? clr_q : v_q),
		.wdata(cmd.clear_step ? '0 : cnt_new),
		.re   (cmd.cnt_read),
		.raddr(elem_rd),
		.rdata(cnt_rd)
	);

endmodule
`default_nettype wire

// ===== hdl/sliding_window_distinct_count.sv =====
// Range distinct-count engine over a stored array.
// Input channel (in_valid/in_ready) takes one word: mode 0 writes elem_value
// at position, mode 1 asks for the number of distinct values in
// left_end..right_end. Output channel (out_valid/out_ready) gives one word per
// query: distinct_count, and bad_query set (with count 0) when left_end
// exceeds right_end. Loads give no output word.
// A query is checked, then each window edge move from the previous range
// takes a plan, an element read, a count read and a count write, until the
// window matches the query; then the result goes into its register. A
// flagged query goes from the check straight to its result, and the first
// query after reset also seeds the window at left_end. A load reduces its
// value when VALUE_RANGE is below 1024, and when its position lies in the
// current window counts the old element out before the store write and the
// new one in after it. One word is worked on at a time; the chained
// registered reads of element and count set the step cost.
// After reset the count table is cleared one entry a cycle, with in_ready
// low. A stalled receiver holds the finished result in the output register;
// the next word is still accepted and worked on, and the following query
// waits at its end until that register frees.
`default_nettype none
module sliding_window_distinct_count #(
	parameter int ARRAY_DEPTH = 1024,
	parameter int VALUE_RANGE = 1024
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output      logic                    in_ready,
	input  wire logic                    mode,
	input  wire logic [swdc_pkg::PW-1:0] position,
	input  wire logic [swdc_pkg::PW-1:0] elem_value,
	input  wire logic [swdc_pkg::PW-1:0] left_end,
	input  wire logic [swdc_pkg::PW-1:0] right_end,
	output      logic                    out_valid,
	input  wire logic                    out_ready,
	output      logic [swdc_pkg::CW-1:0] distinct_count,
	output      logic                    bad_query
);
	import swdc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer
	swdc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.mode    (mode),
		.in_ready(in_ready),
		.cmd     (cmd),
		.sts     (sts)
	);

	// Window, count table and element store
	swdc_dp #(
		.ARRAY_DEPTH(ARRAY_DEPTH),
		.VALUE_RANGE(VALUE_RANGE)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.position      (position),
		.elem_value    (elem_value),
		.left_end      (left_end),
		.right_end     (right_end),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.distinct_count(distinct_count),
		.bad_query     (bad_query)
	);

endmodule
`default_nettype wire
